// ----- rtl/length_prefixed_frame_ring_defines.svh -----
// ----------------------------------------------------------------------------
// Frame ring assertion macros
// Assertion macros used by the checker file of the frame ring.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_RING_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RING_DEFINES_SVH

// Checks a property on every rising edge of clk outside reset.
`define LPFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LPFR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/lpfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame ring package
// Shared sizes, types, codes and index arithmetic of the frame ring.
// ----------------------------------------------------------------------------
package lpfr_pkg;

    localparam int RING_BYTES = 262144;
    localparam int RING2      = 2 * RING_BYTES;
    localparam int IDX_W      = $clog2(RING2);
    localparam int AW         = $clog2(RING_BYTES);
    localparam int SUM_W      = (IDX_W > 16) ? IDX_W + 1 : 18;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [AW-1:0]    addr_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       frame_end;
    } item_t;

    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_MIN_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_COMMIT  = 3'd1;
    localparam logic [2:0] ST_BAD_LEN = 3'd2;
    localparam logic [2:0] ST_NO_ROOM = 3'd3;
    localparam logic [2:0] ST_CORRUPT = 3'd4;

    function automatic idx_t idx_add(idx_t a, logic [12:0] n);
        logic [IDX_W:0] s;
        s = {1'b0, a} + (IDX_W+1)'(n);
        if (s >= (IDX_W+1)'(RING2))
            s = s - (IDX_W+1)'(RING2);
        return s[IDX_W-1:0];
    endfunction

    function automatic addr_t idx_pos(idx_t a);
        idx_t p;
        p = (a >= IDX_W'(RING_BYTES)) ? a - IDX_W'(RING_BYTES) : a;
        return p[AW-1:0];
    endfunction

endpackage

// ----- rtl/lpfr_ram.sv -----
// ----------------------------------------------------------------------------
// Frame ring byte store
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lpfr_ram #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lpfr_front.sv -----
// ----------------------------------------------------------------------------
// Frame ring front end
// Takes command words and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lpfr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lpfr_pkg::item_t item_in,
    output logic           item_valid,
    output lpfr_pkg::item_t item_out,
    input  logic           item_take
);
    import lpfr_pkg::*;

    item_t      slot_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] count_reg;
    logic       enq;
    logic       deq;

    assign busy       = (count_reg == 2'd2);
    assign enq        = start && !busy;
    assign item_valid = (count_reg != 2'd0);
    assign deq        = item_take && item_valid;
    assign item_out   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (deq)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, enq} - {1'b0, deq};
        end
    end

endmodule

// ----- rtl/lpfr_back.sv -----
// ----------------------------------------------------------------------------
// Frame ring back end
// Carries out push and pop words against the byte store and returns results.
// ----------------------------------------------------------------------------
module lpfr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  lpfr_pkg::item_t item,
    output logic            item_take,
    input  logic            cfg_write,
    input  logic [1:0]      cfg_index,
    input  logic [11:0]     cfg_data,
    output logic            done,
    output logic [2:0]      status,
    output logic            pop_valid,
    output logic [7:0]      pop_data,
    output logic            pop_last,
    output logic [18:0]     used_bytes,
    output logic [31:0]     frames_accepted,
    output logic [31:0]     frames_dropped
);
    import lpfr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_HDR_LO, S_HDR_HI, S_RD_LO, S_RD_HI, S_RD_DATA, S_DATA, S_EMIT
    } state_t;

    state_t      state_reg;
    idx_t        head_reg;
    idx_t        tail_reg;
    logic [15:0] pc_reg;
    logic        ovf_reg;
    logic [15:0] rem_reg;
    logic [31:0] acc_reg;
    logic [31:0] drop_reg;
    logic        en_reg;
    logic [11:0] min_reg;
    logic [11:0] max_reg;
    logic [2:0]  stat_reg;
    logic        pv_reg;
    logic [7:0]  pd_reg;
    logic        pl_reg;
    logic [11:0] len_reg;
    logic [7:0]  lo_reg;

    logic        done_reg;
    logic [2:0]  status_reg;
    logic        pop_valid_reg;
    logic [7:0]  pop_data_reg;
    logic        pop_last_reg;
    logic [18:0] used_bytes_reg;
    logic [31:0] accepted_reg;
    logic [31:0] dropped_reg;

    idx_t        used;
    logic        pc_below;
    logic        fits;
    logic        store;
    logic        ovf_next;
    logic [15:0] pc_next;
    logic [15:0] rd_len;
    logic [15:0] rem_next;
    logic        we;
    addr_t       waddr;
    logic [7:0]  wdata;
    addr_t       raddr;
    logic [7:0]  rdata;

    assign used = (head_reg >= tail_reg) ? head_reg - tail_reg
                                         : head_reg + IDX_W'(RING2) - tail_reg;
    assign pc_below = (pc_reg < {4'd0, max_reg});
    assign fits     = (SUM_W'(used) + SUM_W'(pc_reg) + SUM_W'(3)) <= SUM_W'(RING_BYTES);
    assign store    = en_reg && pc_below && fits;
    assign ovf_next = ovf_reg || (pc_below && !fits);
    assign pc_next  = (pc_reg != 16'hffff) ? pc_reg + 16'd1 : pc_reg;
    assign rd_len   = {rdata, lo_reg};
    assign rem_next = rem_reg - 16'd1;
    assign item_take = (state_reg == S_IDLE);

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_pos(idx_add(head_reg, 13'(pc_reg[11:0]) + 13'd2));
        wdata = item.data_byte;
        raddr = idx_pos(tail_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                we = item_valid && (item.opcode == OP_PUSH) && store;
            end
            S_HDR_LO:
            begin
                we    = 1'b1;
                waddr = idx_pos(head_reg);
                wdata = len_reg[7:0];
            end
            S_HDR_HI:
            begin
                we    = 1'b1;
                waddr = idx_pos(idx_add(head_reg, 13'd1));
                wdata = {4'd0, len_reg[11:8]};
            end
            S_RD_LO:
            begin
                raddr = idx_pos(idx_add(tail_reg, 13'd1));
            end
            default:
            begin
            end
        endcase
    end

    lpfr_ram #(
        .DEPTH (RING_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            pc_reg         <= '0;
            ovf_reg        <= 1'b0;
            rem_reg        <= '0;
            acc_reg        <= '0;
            drop_reg       <= '0;
            en_reg         <= 1'b0;
            min_reg        <= 12'd14;
            max_reg        <= 12'd1600;
            stat_reg       <= ST_NONE;
            pv_reg         <= 1'b0;
            pd_reg         <= '0;
            pl_reg         <= 1'b0;
            len_reg        <= '0;
            lo_reg         <= '0;
            done_reg       <= 1'b0;
            status_reg     <= ST_NONE;
            pop_valid_reg  <= 1'b0;
            pop_data_reg   <= '0;
            pop_last_reg   <= 1'b0;
            used_bytes_reg <= '0;
            accepted_reg   <= '0;
            dropped_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        pv_reg    <= 1'b0;
                        pd_reg    <= '0;
                        pl_reg    <= 1'b0;
                        stat_reg  <= ST_NONE;
                        state_reg <= S_EMIT;
                        if (item.opcode == OP_PUSH)
                        begin
                            if (!en_reg)
                            begin
                                if (item.frame_end)
                                begin
                                    drop_reg <= drop_reg + 32'd1;
                                    stat_reg <= ST_BAD_LEN;
                                end
                            end
                            else if (!item.frame_end)
                            begin
                                pc_reg  <= pc_next;
                                ovf_reg <= ovf_next;
                            end
                            else
                            begin
                                pc_reg  <= '0;
                                ovf_reg <= 1'b0;
                                if (pc_next < {4'd0, min_reg} || pc_next > {4'd0, max_reg})
                                begin
                                    drop_reg <= drop_reg + 32'd1;
                                    stat_reg <= ST_BAD_LEN;
                                end
                                else if (ovf_next)
                                begin
                                    drop_reg <= drop_reg + 32'd1;
                                    stat_reg <= ST_NO_ROOM;
                                end
                                else
                                begin
                                    len_reg   <= pc_next[11:0];
                                    stat_reg  <= ST_COMMIT;
                                    state_reg <= S_HDR_LO;
                                end
                            end
                        end
                        else if (rem_reg == 16'd0)
                        begin
                            if (used == '0)
                            begin
                                stat_reg <= ST_NONE;
                            end
                            else if (used < IDX_W'(2))
                            begin
                                tail_reg <= head_reg;
                                stat_reg <= ST_CORRUPT;
                            end
                            else
                            begin
                                state_reg <= S_RD_LO;
                            end
                        end
                        else if (used == '0)
                        begin
                            rem_reg  <= '0;
                            tail_reg <= head_reg;
                            stat_reg <= ST_CORRUPT;
                        end
                        else
                        begin
                            state_reg <= S_DATA;
                        end
                    end
                end
                S_HDR_LO:
                begin
                    state_reg <= S_HDR_HI;
                end
                S_HDR_HI:
                begin
                    head_reg  <= idx_add(head_reg, {1'b0, len_reg} + 13'd2);
                    acc_reg   <= acc_reg + 32'd1;
                    state_reg <= S_EMIT;
                end
                S_RD_LO:
                begin
                    lo_reg    <= rdata;
                    state_reg <= S_RD_HI;
                end
                S_RD_HI:
                begin
                    if (rd_len == 16'd0 || rd_len > {4'd0, max_reg}
                        || (SUM_W'(rd_len) + SUM_W'(2)) > SUM_W'(used))
                    begin
                        tail_reg  <= head_reg;
                        stat_reg  <= ST_CORRUPT;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        tail_reg  <= idx_add(tail_reg, 13'd2);
                        rem_reg   <= rd_len;
                        state_reg <= S_RD_DATA;
                    end
                end
                S_RD_DATA:
                begin
                    state_reg <= S_DATA;
                end
                S_DATA:
                begin
                    pv_reg    <= 1'b1;
                    pd_reg    <= rdata;
                    pl_reg    <= (rem_next == 16'd0);
                    rem_reg   <= rem_next;
                    tail_reg  <= idx_add(tail_reg, 13'd1);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    done_reg       <= 1'b1;
                    status_reg     <= stat_reg;
                    pop_valid_reg  <= pv_reg;
                    pop_data_reg   <= pd_reg;
                    pop_last_reg   <= pl_reg;
                    used_bytes_reg <= 19'(used);
                    accepted_reg   <= acc_reg;
                    dropped_reg    <= drop_reg;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_ENABLED:
                    begin
                        en_reg   <= cfg_data[0];
                        head_reg <= '0;
                        tail_reg <= '0;
                        pc_reg   <= '0;
                        ovf_reg  <= 1'b0;
                        rem_reg  <= '0;
                    end
                    CFG_MIN_LEN:
                    begin
                        min_reg <= cfg_data;
                    end
                    CFG_MAX_LEN:
                    begin
                        max_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign pop_valid       = pop_valid_reg;
    assign pop_data        = pop_data_reg;
    assign pop_last        = pop_last_reg;
    assign used_bytes      = used_bytes_reg;
    assign frames_accepted = accepted_reg;
    assign frames_dropped  = dropped_reg;

endmodule

// ----- rtl/length_prefixed_frame_ring.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed frame ring
// Byte ring that stores whole frames behind a two-byte length and pops them back.
// ----------------------------------------------------------------------------
// Each word returns one result on done, which the receiver must take in that
// cycle. A committing push writes the two header bytes after the data, and a
// pop that opens a frame reads the header before its first data byte, since
// the single read port of the byte store fetches the two header bytes and the
// data byte one after another. A two-word queue in front lets start be taken
// while the execution unit is still working.
module length_prefixed_frame_ring (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic        pop_valid,
    output logic [7:0]  pop_data,
    output logic        pop_last,
    output logic [18:0] used_bytes,
    output logic [31:0] frames_accepted,
    output logic [31:0] frames_dropped
);
    import lpfr_pkg::*;

    item_t item_in;
    item_t item_q;
    logic  item_valid;
    logic  item_take;

    assign item_in.opcode    = opcode;
    assign item_in.data_byte = data_byte;
    assign item_in.frame_end = frame_end;
    assign cfg_ready         = 1'b1;

    lpfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item_in    (item_in),
        .item_valid (item_valid),
        .item_out   (item_q),
        .item_take  (item_take)
    );

    lpfr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item            (item_q),
        .item_take       (item_take),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .status          (status),
        .pop_valid       (pop_valid),
        .pop_data        (pop_data),
        .pop_last        (pop_last),
        .used_bytes      (used_bytes),
        .frames_accepted (frames_accepted),
        .frames_dropped  (frames_dropped)
    );

endmodule

// ----- rtl/lpfr_checker.sv -----
// ----------------------------------------------------------------------------
// Frame ring checker
// Port-level assertions on the results of the frame ring.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_ring_defines.svh"

module lpfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [2:0]  status,
    input logic        pop_valid,
    input logic [7:0]  pop_data,
    input logic        pop_last,
    input logic [31:0] frames_accepted,
    input logic [31:0] frames_dropped
);
    import lpfr_pkg::*;

`LPFR_ASSERT(a_status_code, done |-> (status <= ST_CORRUPT), "Undefined status code.")
`LPFR_ASSERT(a_pop_status, (done && pop_valid) |-> (status == ST_NONE), "Pop with a status.")
`LPFR_ASSERT(a_pop_empty, !pop_valid |-> (pop_data == '0 && !pop_last), "Empty pop with data.")
`LPFR_ASSERT(a_acc_stable, !done |-> $stable(frames_accepted), "Accepted count moved.")
`LPFR_ASSERT_NEXT(a_done_gap, done, !done, "Results came back to back.")

endmodule

bind length_prefixed_frame_ring lpfr_checker u_lpfr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .done            (done),
    .status          (status),
    .pop_valid       (pop_valid),
    .pop_data        (pop_data),
    .pop_last        (pop_last),
    .frames_accepted (frames_accepted),
    .frames_dropped  (frames_dropped)
);

// ----- tb/sv/length_prefixed_frame_ring_tb.sv -----
// ----------------------------------------------------------------------------
// Frame ring regression testbench
// Drives push and pop words into the frame ring, predicts every result word
// from an independent model of the ring and checks each one field by field.
// A directed table covers the special cases, and random frames and pops
// follow under changing sender idling.
// ----------------------------------------------------------------------------
module length_prefixed_frame_ring_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfr_pkg::*;

    localparam int RBYTES = lpfr_pkg::RING_BYTES;

    typedef struct {
        logic [2:0]  status;
        logic        pop_valid;
        logic [7:0]  pop_data;
        logic        pop_last;
        logic [18:0] used_bytes;
        logic [31:0] frames_accepted;
        logic [31:0] frames_dropped;
    } ring_result_t;

    typedef enum {ROW_FRAME, ROW_POP, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        int          count;
        logic [1:0]  cfg_idx;
        logic [11:0] value;
        bit          typed;
        logic [2:0]  status;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        opcode = OP_PUSH;
    logic [7:0]  data_byte = 8'd0;
    logic        frame_end = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ENABLED;
    logic [11:0] cfg_data = 12'd0;
    logic        done;
    logic [2:0]  status;
    logic        pop_valid;
    logic [7:0]  pop_data;
    logic        pop_last;
    logic [18:0] used_bytes;
    logic [31:0] frames_accepted;
    logic [31:0] frames_dropped;

    ring_result_t pending_results[$];
    bit           failed = 1'b0;
    int           idle_pct = 0;

    logic [7:0]  ring_copy [RBYTES];
    int          head_ptr, tail_ptr, push_len, pop_left;
    bit          push_ovf;
    logic [31:0] commit_cnt, drop_cnt;
    bit          ring_on;
    int          len_min, len_max;

    length_prefixed_frame_ring dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("length_prefixed_frame_ring regression: fail");
        $finish;
    end

    function automatic int ptr_add(int a, int n);
        int s;
        s = a + n;
        if (s >= 2 * RBYTES)
            s -= 2 * RBYTES;
        return s;
    endfunction

    function automatic int ptr_pos(int a);
        return (a >= RBYTES) ? a - RBYTES : a;
    endfunction

    function automatic int ring_fill();
        return (head_ptr >= tail_ptr) ? head_ptr - tail_ptr : head_ptr + 2 * RBYTES - tail_ptr;
    endfunction

    function automatic void clear_ring();
        head_ptr = 0;
        tail_ptr = 0;
        push_len = 0;
        push_ovf = 1'b0;
        pop_left = 0;
    endfunction

    function automatic logic [2:0] push_byte(logic [7:0] b, logic last);
        logic [2:0] st;
        st = ST_NONE;
        if (!ring_on)
        begin
            if (last)
            begin
                drop_cnt++;
                st = ST_BAD_LEN;
            end
            return st;
        end
        if (push_len < len_max)
        begin
            if (ring_fill() + 2 + push_len + 1 <= RBYTES)
                ring_copy[ptr_pos(ptr_add(head_ptr, 2 + push_len))] = b;
            else
                push_ovf = 1'b1;
        end
        if (push_len < 65535)
            push_len++;
        if (!last)
            return ST_NONE;
        if (push_len < len_min || push_len > len_max)
        begin
            drop_cnt++;
            st = ST_BAD_LEN;
        end
        else if (push_ovf)
        begin
            drop_cnt++;
            st = ST_NO_ROOM;
        end
        else
        begin
            ring_copy[ptr_pos(head_ptr)] = push_len[7:0];
            ring_copy[ptr_pos(ptr_add(head_ptr, 1))] = push_len[15:8];
            head_ptr = ptr_add(head_ptr, 2 + push_len);
            commit_cnt++;
            st = ST_COMMIT;
        end
        push_len = 0;
        push_ovf = 1'b0;
        return st;
    endfunction

    function automatic logic [2:0] pop_byte(ref ring_result_t r);
        int fill, len;
        fill = ring_fill();
        if (pop_left == 0)
        begin
            if (fill == 0)
                return ST_NONE;
            if (fill < 2)
            begin
                tail_ptr = head_ptr;
                return ST_CORRUPT;
            end
            len = {ring_copy[ptr_pos(ptr_add(tail_ptr, 1))], ring_copy[ptr_pos(tail_ptr)]};
            if (len == 0 || len > len_max || 2 + len > fill)
            begin
                tail_ptr = head_ptr;
                return ST_CORRUPT;
            end
            tail_ptr = ptr_add(tail_ptr, 2);
            pop_left = len;
        end
        if (ring_fill() == 0)
        begin
            pop_left = 0;
            tail_ptr = head_ptr;
            return ST_CORRUPT;
        end
        r.pop_valid = 1'b1;
        r.pop_data = ring_copy[ptr_pos(tail_ptr)];
        tail_ptr = ptr_add(tail_ptr, 1);
        pop_left--;
        r.pop_last = (pop_left == 0);
        return ST_NONE;
    endfunction

    function automatic ring_result_t ring_predict(logic op, logic [7:0] b, logic last);
        ring_result_t r;
        r.pop_valid = 1'b0;
        r.pop_data = 8'd0;
        r.pop_last = 1'b0;
        if (op == OP_PUSH)
            r.status = push_byte(b, last);
        else
            r.status = pop_byte(r);
        r.used_bytes = 19'(ring_fill());
        r.frames_accepted = commit_cnt;
        r.frames_dropped = drop_cnt;
        return r;
    endfunction

    task automatic send_word(logic op, logic [7:0] b, logic last, bit typed = 1'b0,
                             logic [2:0] typed_status = ST_NONE);
        ring_result_t r;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        data_byte <= b;
        frame_end <= last;
        do
            @(posedge clk);
        while (busy);
        r = ring_predict(op, b, last);
        if (typed)
            r.status = typed_status;
        pending_results.push_back(r);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLED:
            begin
                ring_on = value[0];
                clear_ring();
            end
            CFG_MIN_LEN: len_min = value;
            CFG_MAX_LEN: len_max = value;
            default: ;
        endcase
    endtask

    task automatic send_frame(int n, logic [7:0] b = 8'd0, bit rnd = 1'b1, bit typed = 1'b0,
                              logic [2:0] typed_status = ST_NONE);
        for (int i = 0; i < n; i++)
            send_word(OP_PUSH, rnd ? 8'($urandom) : b, i == n - 1, typed && i == n - 1,
                      typed_status);
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        ring_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected");
                failed = 1'b1;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("status", e.status, status);
                check_field("pop_valid", e.pop_valid, pop_valid);
                check_field("pop_data", e.pop_data, pop_data);
                check_field("pop_last", e.pop_last, pop_last);
                check_field("used_bytes", e.used_bytes, used_bytes);
                check_field("frames_accepted", e.frames_accepted, frames_accepted);
                check_field("frames_dropped", e.frames_dropped, frames_dropped);
            end
        end
    end

    stim_row_t directed[] = '{
        '{ROW_FRAME, 1, CFG_ENABLED, 12'h000, 1'b1, ST_BAD_LEN},
        '{ROW_POP,   1, CFG_ENABLED, 12'h0ff, 1'b1, ST_NONE},
        '{ROW_CFG,   0, CFG_ENABLED, 12'd1,   1'b0, ST_NONE},
        '{ROW_CFG,   0, CFG_MIN_LEN, 12'd3,   1'b0, ST_NONE},
        '{ROW_CFG,   0, CFG_MAX_LEN, 12'd14,  1'b0, ST_NONE},
        '{ROW_FRAME, 3, CFG_ENABLED, 12'h0ff, 1'b1, ST_COMMIT},
        '{ROW_FRAME, 2, CFG_ENABLED, 12'h0a5, 1'b1, ST_BAD_LEN},
        '{ROW_FRAME, 15, CFG_ENABLED, 12'h05a, 1'b1, ST_BAD_LEN},
        '{ROW_POP,   3, CFG_ENABLED, 12'h000, 1'b0, ST_NONE},
        '{ROW_POP,   1, CFG_ENABLED, 12'h000, 1'b1, ST_NONE},
        '{ROW_CFG,   0, CFG_MIN_LEN, 12'd1,   1'b0, ST_NONE},
        '{ROW_CFG,   0, CFG_MAX_LEN, 12'd4095, 1'b0, ST_NONE},
        '{ROW_FRAME, 20, CFG_ENABLED, 12'h000, 1'b1, ST_COMMIT},
        '{ROW_CFG,   0, CFG_MAX_LEN, 12'd14,  1'b0, ST_NONE},
        '{ROW_POP,   1, CFG_ENABLED, 12'h0ff, 1'b1, ST_CORRUPT},
        '{ROW_CFG,   0, CFG_MIN_LEN, 12'd4095, 1'b0, ST_NONE},
        '{ROW_FRAME, 1, CFG_ENABLED, 12'h0ff, 1'b1, ST_BAD_LEN},
        '{ROW_CFG,   0, CFG_MIN_LEN, 12'd1,   1'b0, ST_NONE},
        '{ROW_FRAME, 14, CFG_ENABLED, 12'h000, 1'b1, ST_COMMIT},
        '{ROW_POP,   1, CFG_ENABLED, 12'h000, 1'b0, ST_NONE},
        '{ROW_CFG,   0, CFG_ENABLED, 12'd0,   1'b0, ST_NONE},
        '{ROW_POP,   1, CFG_ENABLED, 12'h000, 1'b1, ST_NONE},
        '{ROW_FRAME, 1, CFG_ENABLED, 12'h000, 1'b1, ST_BAD_LEN}
    };

    initial
    begin
        int sent, target, n;
        ring_on = 1'b0;
        len_min = 14;
        len_max = 1600;
        commit_cnt = '0;
        drop_cnt = '0;
        clear_ring();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            case (directed[i].kind)
                ROW_CFG: write_reg(directed[i].cfg_idx, directed[i].value);
                ROW_FRAME: send_frame(directed[i].count, directed[i].value[7:0], 1'b0,
                                      directed[i].typed, directed[i].status);
                default:
                    for (int k = 0; k < directed[i].count; k++)
                        send_word(OP_POP, directed[i].value[7:0], k[0], directed[i].typed,
                                  directed[i].status);
            endcase
        end

        write_reg(CFG_ENABLED, 12'd1);

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 24 : (ph == 1) ? 76 : 0;
            write_reg(CFG_MIN_LEN, 12'($urandom_range(1, 12)));
            write_reg(CFG_MAX_LEN, 12'($urandom_range(14, 64)));
            if (ph == 1)
                write_reg(CFG_ENABLED, 12'd0);
            else if (ph == 2)
                write_reg(CFG_ENABLED, 12'd1);
            sent = 0;
            target = (ph == 1) ? 60 : 0;
            while (sent < target)
            begin
                send_word(1'($urandom), 8'($urandom), 1'($urandom));
                sent++;
            end
            if (ph == 1)
                write_reg(CFG_ENABLED, 12'd1);
            sent = 0;
            while (sent < 430)
            begin
                if ($urandom_range(99) < 40)
                begin
                    send_word(OP_POP, 8'($urandom), 1'($urandom));
                    sent++;
                end
                else
                begin
                    if ($urandom_range(99) < 12)
                        n = $urandom_range(1, 80);
                    else
                        n = $urandom_range(len_min, len_max);
                    send_frame(n);
                    sent += n;
                end
                if (sent > 200 && sent < 230 && ph == 0)
                    wait_drained();
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (!failed)
            $display("length_prefixed_frame_ring regression: pass");
        else
            $display("length_prefixed_frame_ring regression: fail");
        $finish;
    end
endmodule

// ----- length_prefixed_frame_ring.f -----
+incdir+rtl
rtl/lpfr_pkg.sv
rtl/lpfr_ram.sv
rtl/lpfr_front.sv
rtl/lpfr_back.sv
rtl/length_prefixed_frame_ring.sv
rtl/lpfr_checker.sv
tb/sv/length_prefixed_frame_ring_tb.sv
